// ===== hw/rtl/keyed_fnv_auth_digest_assert.svh =====
// Assertion macros used by the digest control RTL.
`ifndef KEYED_FNV_AUTH_DIGEST_ASSERT_SVH
`define KEYED_FNV_AUTH_DIGEST_ASSERT_SVH

`ifndef SYNTHESIS
`define KFAD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define KFAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define KFAD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define KFAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/kfad_pkg.sv =====
package kfad_pkg;

	localparam int WORD_W    = 64;
	localparam int SEQ_W     = 48;
	localparam int CFG_IDX_W = 8;
	localparam int BYTE_W    = 8;
	localparam int STEPS     = 32;
	localparam int CNT_W     = $clog2(STEPS);
	localparam int DATA_W    = STEPS * BYTE_W;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

	localparam logic [WORD_W-1:0] DIG_SEED    = 64'h9e3779b97f4a7c15;
	localparam logic [WORD_W-1:0] DOMAIN_RESP = 64'h0000000052455350;
	localparam logic [WORD_W-1:0] DOMAIN_MAC  = 64'h00000000004d4143;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 8'd1;

	localparam logic REQ_RESPONSE = 1'b0;
	localparam logic REQ_MAC      = 1'b1;

	typedef struct packed {
		logic load;
		logic step;
		logic emit;
	} kfad_cmd_t;

	// One fold: xor in the byte, then multiply by 2^40 + 0x1b3 modulo 2^64.
	function automatic logic [WORD_W-1:0] fnv_step(input logic [WORD_W-1:0] acc,
		input logic [BYTE_W-1:0] b);
		logic [WORD_W-1:0] x;
		x = acc ^ {{(WORD_W-BYTE_W){1'b0}}, b};
		return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
	endfunction

endpackage

// ===== hw/rtl/kfad_ifs.sv =====
interface kfad_cfg_if
	import kfad_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [WORD_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

interface kfad_req_if
	import kfad_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [WORD_W-1:0] challenge_low;
	logic [WORD_W-1:0] challenge_high;
	logic [SEQ_W-1:0]  sequence_number;

	modport source (output valid, output req_type, output challenge_low,
		output challenge_high, output sequence_number, input ready);
	modport sink (input valid, input req_type, input challenge_low,
		input challenge_high, input sequence_number, output ready);
endinterface

interface kfad_rsp_if
	import kfad_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] digest;

	modport source (output valid, output digest, input ready);
	modport sink (input valid, input digest, output ready);
endinterface

// ===== hw/rtl/kfad_ctrl.sv =====
`include "keyed_fnv_auth_digest_assert.svh"

module kfad_ctrl
	import kfad_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output kfad_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;

	logic last;
	logic out_free;
	logic emit;
	logic accept;

	always_comb begin
		last     = (state_q == ST_RUN) && (cnt_q == CNT_LAST);
		out_free = !out_valid_q || out_ready;
		emit     = (last || (state_q == ST_HOLD)) && out_free;
		in_ready = (state_q == ST_IDLE) || emit;
		accept   = in_valid && in_ready;
		cmd.load = accept;
		cmd.step = (state_q == ST_RUN);
		cmd.emit = emit;
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					if (last) begin
						if (accept) begin
							cnt_q <= '0;
						end else if (emit) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_HOLD;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_HOLD: begin
					if (accept) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end else if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`KFAD_ASSERT_IMPLY(a_no_load_mid_run, clk, arst_n,
		cmd.load, !((state_q == ST_RUN) && !last), "request taken in the middle of a run")
	`KFAD_ASSERT_NEXT(a_run_advances, clk, arst_n,
		(state_q == ST_RUN) && !last,
		(state_q == ST_RUN) && (cnt_q == $past(cnt_q) + 1'b1), "fold counter did not advance")
	`KFAD_ASSERT_NEXT(a_blocked_holds, clk, arst_n,
		last && !out_free, (state_q == ST_HOLD) && out_valid_q,
		"finished digest not held while the output is blocked")

endmodule

// ===== hw/rtl/kfad_datapath.sv =====
module kfad_datapath
	import kfad_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	kfad_cfg_if.sink          cfg,
	input  kfad_cmd_t         cmd,
	input  logic              req_type,
	input  logic [WORD_W-1:0] challenge_low,
	input  logic [WORD_W-1:0] challenge_high,
	input  logic [SEQ_W-1:0]  sequence_number,
	output logic [WORD_W-1:0] digest
);

	logic [WORD_W-1:0] key_low_q;
	logic [WORD_W-1:0] key_high_q;
	logic [WORD_W-1:0] acc_q;
	logic [DATA_W-1:0] data_q;
	logic [WORD_W-1:0] digest_q;

	logic [WORD_W-1:0] acc_next;
	logic [WORD_W-1:0] msg_low;
	logic [WORD_W-1:0] seed;

	assign cfg.ready = 1'b1;

	always_comb begin
		acc_next = fnv_step(acc_q, data_q[BYTE_W-1:0]);
		if (req_type == REQ_MAC) begin
			msg_low = challenge_low ^ {{(WORD_W-SEQ_W){1'b0}}, sequence_number};
			seed    = DIG_SEED ^ DOMAIN_MAC;
		end else begin
			msg_low = challenge_low;
			seed    = DIG_SEED ^ DOMAIN_RESP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_KEY_LOW:  key_low_q  <= cfg.data;
				REG_KEY_HIGH: key_high_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q  <= seed;
			data_q <= {challenge_high, msg_low, key_high_q, key_low_q};
		end else if (cmd.step) begin
			acc_q  <= acc_next;
			data_q <= data_q >> BYTE_W;
		end
		if (cmd.emit) begin
			digest_q <= cmd.step ? acc_next : acc_q;
		end
	end

	assign digest = digest_q;

endmodule

// ===== hw/rtl/keyed_fnv_auth_digest.sv =====
// Keyed 64-bit FNV-1a style digest over a 16-byte key and a 16-byte message.
// The key is loaded through the cfg channel: index 0 writes key bytes 0 to 7,
// index 1 writes key bytes 8 to 15; other indexes are ignored. The cfg channel
// is always ready and should only be written while no request is in flight.
// Each req transfer carries a request type, a 128-bit challenge and a 48-bit
// sequence number; each produces exactly one rsp transfer with the digest.
// The datapath folds one byte per cycle through a single multiply-by-prime
// unit. The digest is registered with the last byte's fold; while the output
// register is free, the next request is taken in that same cycle.
// The digest sits in an output register, so the next request is accepted
// and folded while a finished digest waits. If rsp is still stalled when the
// next fold completes, the block holds that result and stops taking requests
// until the output register drains.
// Reset clears both key registers to zero and empties the block.

module keyed_fnv_auth_digest
	import kfad_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	kfad_cfg_if.sink   cfg,
	kfad_req_if.sink   req,
	kfad_rsp_if.source rsp
);

	kfad_cmd_t cmd;
	logic      in_ready;
	logic      out_valid;

	kfad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	kfad_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.cmd             (cmd),
		.req_type        (req.req_type),
		.challenge_low   (req.challenge_low),
		.challenge_high  (req.challenge_high),
		.sequence_number (req.sequence_number),
		.digest          (rsp.digest)
	);

	assign req.ready = in_ready;
	assign rsp.valid = out_valid;

endmodule

// ===== verif/tb_top.sv =====
module tb_top
	import kfad_pkg::*;
;

	localparam logic [WORD_W-1:0]    DIGEST_PRIME   = 64'h00000100000001b3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = 8'hff;
	localparam logic [WORD_W-1:0]    ALL_ONES       = '1;
	localparam logic [SEQ_W-1:0]     SEQ_MAX        = '1;
	localparam int SETTLE_CYCLES  = 40;
	localparam int CYCLE_LIMIT    = 500000;
	localparam int RANDOM_PHASES  = 5;
	localparam int PHASE_REQUESTS = 270;
	localparam int HOLD_CYCLES    = 700;

	class digest_scoreboard;
		logic [WORD_W-1:0] key_low;
		logic [WORD_W-1:0] key_high;
		logic [WORD_W-1:0] expected_digests[$];
		int errors;

		function new();
			key_low = '0;
			key_high = '0;
			errors = 0;
		endfunction

		function void write_key(logic [CFG_IDX_W-1:0] index, logic [WORD_W-1:0] data);
			if (index == REG_KEY_LOW) begin
				key_low = data;
			end else if (index == REG_KEY_HIGH) begin
				key_high = data;
			end
		endfunction

		function logic [WORD_W-1:0] fold_word(logic [WORD_W-1:0] acc, logic [WORD_W-1:0] word);
			for (int i = 0; i < 8; i++) begin
				acc = (acc ^ {56'd0, word[8*i +: 8]}) * DIGEST_PRIME;
			end
			return acc;
		endfunction

		function void note_request(logic kind, logic [WORD_W-1:0] chal_low,
			logic [WORD_W-1:0] chal_high, logic [SEQ_W-1:0] seq);
			logic [WORD_W-1:0] acc;
			logic [WORD_W-1:0] msg_low;
			msg_low = chal_low;
			if (kind == REQ_MAC) begin
				msg_low = chal_low ^ {16'd0, seq};
				acc = DIG_SEED ^ DOMAIN_MAC;
			end else begin
				acc = DIG_SEED ^ DOMAIN_RESP;
			end
			acc = fold_word(acc, key_low);
			acc = fold_word(acc, key_high);
			acc = fold_word(acc, msg_low);
			acc = fold_word(acc, chal_high);
			expected_digests.push_back(acc);
		endfunction

		function void check_digest(logic [WORD_W-1:0] actual);
			logic [WORD_W-1:0] wanted;
			if (expected_digests.size() == 0) begin
				$error("digest: unexpected transfer, actual %h", actual);
				errors++;
			end else begin
				wanted = expected_digests.pop_front();
				if (actual !== wanted) begin
					$error("digest mismatch: expected %h, actual %h", wanted, actual);
					errors++;
				end
			end
		endfunction

		function int outstanding();
			return expected_digests.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   calm;
	int   hold_request;
	int   hold_left;
	int   cycles;

	kfad_cfg_if cfg_ch();
	kfad_req_if req_ch();
	kfad_rsp_if rsp_ch();

	digest_scoreboard sb = new();

	keyed_fnv_auth_digest uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			sb.check_digest(rsp_ch.digest);
		end
	end

	initial begin
		rsp_ch.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else if (calm) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= 21);
			end
		end
	end

	task automatic write_register(input logic [CFG_IDX_W-1:0] index,
		input logic [WORD_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_key(index, data);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_request(input logic kind, input logic [WORD_W-1:0] chal_low,
		input logic [WORD_W-1:0] chal_high, input logic [SEQ_W-1:0] seq);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 21) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.challenge_low <= chal_low;
		req_ch.challenge_high <= chal_high;
		req_ch.sequence_number <= seq;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(kind, chal_low, chal_high, seq);
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	task automatic settle();
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [WORD_W-1:0] pick_word();
		int roll;
		roll = $urandom_range(99);
		if (roll < 8) return '0;
		if (roll < 16) return ALL_ONES;
		return {$urandom, $urandom};
	endfunction

	function automatic logic [SEQ_W-1:0] pick_sequence();
		int roll;
		logic [63:0] raw;
		roll = $urandom_range(99);
		raw = {$urandom, $urandom};
		if (roll < 8) return '0;
		if (roll < 16) return SEQ_MAX;
		return raw[SEQ_W-1:0];
	endfunction

	initial begin
		cycles = 0;
		calm = 1'b0;
		hold_request = 0;
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_RESPONSE;
		req_ch.challenge_low = '0;
		req_ch.challenge_high = '0;
		req_ch.sequence_number = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The key registers hold their reset value of zero here.
		send_request(REQ_RESPONSE, '0, '0, '0);
		send_request(REQ_RESPONSE, ALL_ONES, ALL_ONES, SEQ_MAX);
		send_request(REQ_MAC, '0, '0, '0);
		send_request(REQ_MAC, '0, '0, SEQ_MAX);
		send_request(REQ_MAC, ALL_ONES, ALL_ONES, SEQ_MAX);
		send_request(REQ_RESPONSE, 64'h0123456789abcdef, 64'hfedcba9876543210,
			48'h555555555555);
		send_request(REQ_MAC, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 48'haaaaaaaaaaaa);
		settle();

		write_register(REG_KEY_LOW, ALL_ONES);
		write_register(REG_KEY_HIGH, ALL_ONES);
		send_request(REQ_RESPONSE, '0, '0, '0);
		send_request(REQ_MAC, '0, ALL_ONES, SEQ_MAX);
		send_request(REQ_MAC, ALL_ONES, '0, 48'h000000000001);
		send_request(REQ_RESPONSE, ALL_ONES, ALL_ONES, '0);
		send_request(REQ_MAC, 64'h8000000000000001, 64'h8000000000000001, 48'h800000000000);
		settle();

		// Writes to unused indexes must leave both key registers unchanged.
		write_register(REG_KEY_LOW, 64'h0f1e2d3c4b5a6978);
		write_register(REG_KEY_HIGH, '0);
		write_register(REG_UNUSED_LOW, ALL_ONES);
		write_register(REG_UNUSED_TOP, {$urandom, $urandom});
		send_request(REQ_RESPONSE, 64'h00000000000000ff, 64'hff00000000000000, '0);
		send_request(REQ_MAC, 64'h0000ffffffffffff, '0, SEQ_MAX);
		send_request(REQ_MAC, {$urandom, $urandom}, {$urandom, $urandom}, pick_sequence());
		send_request(REQ_RESPONSE, {$urandom, $urandom}, {$urandom, $urandom},
			pick_sequence());
		settle();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == 0) begin
				write_register(REG_KEY_LOW, '0);
				write_register(REG_KEY_HIGH, ALL_ONES);
			end else if (phase == 1) begin
				write_register(REG_KEY_LOW, ALL_ONES);
				write_register(REG_KEY_HIGH, '0);
			end else begin
				write_register(REG_KEY_LOW, {$urandom, $urandom});
				write_register(REG_KEY_HIGH, {$urandom, $urandom});
				write_register(CFG_IDX_W'($urandom_range(255, 2)), {$urandom, $urandom});
			end
			calm = (phase == 2);
			if (phase == 3) begin
				hold_request = HOLD_CYCLES;
			end
			for (int n = 0; n < PHASE_REQUESTS; n++) begin
				if (phase == 1 && n == PHASE_REQUESTS / 2) begin
					wait_for_results();
				end
				send_request(logic'($urandom_range(1)), pick_word(), pick_word(),
					pick_sequence());
			end
			calm = 1'b0;
			settle();
		end

		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
